[rtl/core/rmje_pkg.sv]
// Shared constants for the row mean and jackknife error block.
`default_nettype none
package rmje_pkg;
   localparam int unsigned MAX_ROW_LEN_DEF = 1024;
   localparam int unsigned SAMPLE_W        = 32;
   localparam int unsigned ERROR_W         = 31;
   // Squared-deviation accumulator; reaching 2^63 saturates the error.
   localparam int unsigned ACC_W           = 63;
   localparam int unsigned ROOT_W          = 64;
   localparam int unsigned ROOT_STEPS      = 32;
   localparam logic [ERROR_W-1:0] ERROR_MAX = {ERROR_W{1'b1}};
endpackage
`default_nettype wire

[rtl/core/row_mean_jackknife_error.sv]
// Sequence: a row is loaded, then a bit-serial mean divide, a memory pass, two multiplies,
// a bit-serial divide by n^2 and an integer square root produce the result.
// Flow: one row at a time; input stalls from the last item until the result is registered.
// Reset: synchronous, active high; clears count, sum, sequencer and result valid.
// The sample memory is not cleared; only entries written in the current row are read.
`default_nettype none
module row_mean_jackknife_error #(
   parameter int unsigned MAX_ROW_LEN = rmje_pkg::MAX_ROW_LEN_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [rmje_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                                req_last_in_row,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [rmje_pkg::SAMPLE_W-1:0]      rsp_row_mean,
   output logic        [rmje_pkg::ERROR_W-1:0]       rsp_row_error
);
   localparam int unsigned CNT_W  = $clog2(MAX_ROW_LEN + 1);
   localparam int unsigned ADDR_W = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
   localparam int unsigned SUM_W  = rmje_pkg::SAMPLE_W + CNT_W;
   localparam int unsigned ACC_W  = rmje_pkg::ACC_W;
   localparam int unsigned PW     = ACC_W + 2 * CNT_W;
   localparam int unsigned DW     = 2 * CNT_W;
   localparam int unsigned RW     = DW + 1;
   localparam int unsigned IT_W   = $clog2(PW + 1);
   localparam int unsigned RTW    = rmje_pkg::ROOT_W;
   localparam int unsigned XW     = rmje_pkg::SAMPLE_W;

   typedef enum logic [3:0] {
      ST_LOAD, ST_DIV1, ST_FIXQ, ST_PASS, ST_MULA, ST_SUBR, ST_MULB, ST_DIVN, ST_SQRT,
      ST_FINISH
   } state_type;

   state_type                state_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic [CNT_W-1:0]         n_ff;
   logic                     neg_ff;
   logic [PW-1:0]            p_ff;
   logic [PW-1:0]            mcand_ff;
   logic [CNT_W-1:0]         mplier_ff;
   logic [RW-1:0]            rem_ff;
   logic [DW-1:0]            dvs_ff;
   logic [IT_W-1:0]          it_ff;
   logic [XW-1:0]            q_ff;
   logic [CNT_W-1:0]         r_ff;
   logic [XW-1:0]            mean_ff;
   logic [CNT_W-1:0]         rd_ptr_ff;
   logic                     v1_ff, v2_ff, v3_ff;
   logic [XW-1:0]            memq_ff;
   logic [XW:0]              ad_ff;
   logic [2*XW:0]            sq_ff;
   logic [ACC_W-1:0]         acc_ff;
   logic                     sat_ff;
   logic [RTW-1:0]           sv_ff, res_ff, bit_ff;
   logic                     rsp_valid_ff;
   logic [XW-1:0]            rsp_mean_ff;
   logic [rmje_pkg::ERROR_W-1:0] rsp_err_ff;

   logic [XW-1:0] row_mem [MAX_ROW_LEN];

   // load side
   logic                    req_acc;
   logic                    room;
   logic [CNT_W-1:0]        cnt_in;
   logic signed [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0]        mag_in;
   logic                    mem_we;
   logic                    rd_issue;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_acc   = req_valid && req_ready;
   assign room      = (cnt_ff < CNT_W'(MAX_ROW_LEN));
   assign mem_we    = req_acc && room;
   assign cnt_in    = room ? cnt_ff + CNT_W'(1) : cnt_ff;
   assign sum_in    = room ? sum_ff + SUM_W'(req_sample) : sum_ff;
   assign mag_in    = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
   assign rd_issue  = (state_ff == ST_PASS) && (rd_ptr_ff < n_ff);

   // shared restoring divide step
   logic [RW-1:0] rem_sh;
   logic          div_ge;
   assign rem_sh = {rem_ff[RW-2:0], p_ff[PW-1]};
   assign div_ge = (rem_sh >= {1'b0, dvs_ff});

   // quotient sign fix for the mean
   logic [XW-1:0]    qm;
   logic [CNT_W-1:0] rm;
   logic [XW-1:0]    q_fix;
   logic [CNT_W-1:0] r_fix;
   assign qm = p_ff[XW-1:0];
   assign rm = rem_ff[CNT_W-1:0];
   always_comb begin
      if (neg_ff && (rm != '0)) begin
         q_fix = ~qm;
         r_fix = n_ff - rm;
      end else if (neg_ff) begin
         q_fix = -qm;
         r_fix = '0;
      end else begin
         q_fix = qm;
         r_fix = rm;
      end
   end

   // deviation pipeline
   logic signed [XW:0] dev;
   logic [ACC_W+2:0]   acc_sum;
   logic [DW-1:0]      rsq;
   logic [DW-1:0]      nsq;
   assign dev     = $signed({memq_ff[XW-1], memq_ff}) - $signed({q_ff[XW-1], q_ff});
   assign acc_sum = {3'b000, acc_ff} + (ACC_W+3)'(sq_ff);
   assign rsq     = DW'(r_ff) * DW'(r_ff);
   assign nsq     = DW'(n_ff) * DW'(n_ff);

   // integer square root step
   logic [RTW-1:0] rt_try;
   assign rt_try = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[cnt_ff[ADDR_W-1:0]] <= req_sample;
      end
      if (rd_issue) begin
         memq_ff <= row_mem[rd_ptr_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      ad_ff <= dev[XW] ? (XW+1)'(-dev) : (XW+1)'(dev);
      sq_ff <= (2*XW+1)'(ad_ff * ad_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         sat_ff       <= 1'b0;
         it_ff        <= '0;
         rd_ptr_ff    <= '0;
      end else begin
         // in finish the result register is refilled instead
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         v1_ff <= rd_issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         case (state_ff)
            ST_LOAD: begin
               if (req_acc) begin
                  if (req_last_in_row) begin
                     cnt_ff   <= '0;
                     sum_ff   <= '0;
                     n_ff     <= cnt_in;
                     neg_ff   <= sum_in[SUM_W-1];
                     p_ff     <= PW'(mag_in);
                     rem_ff   <= '0;
                     dvs_ff   <= DW'(cnt_in);
                     it_ff    <= '0;
                     state_ff <= ST_DIV1;
                  end else begin
                     cnt_ff <= cnt_in;
                     sum_ff <= sum_in;
                  end
               end
            end
            ST_DIV1, ST_DIVN: begin
               rem_ff <= div_ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
               p_ff   <= {p_ff[PW-2:0], div_ge};
               if (it_ff == IT_W'(PW - 1)) begin
                  it_ff <= '0;
                  if (state_ff == ST_DIV1) begin
                     state_ff <= ST_FIXQ;
                  end else begin
                     state_ff <= ST_SQRT;
                  end
               end else begin
                  it_ff <= it_ff + IT_W'(1);
               end
            end
            ST_FIXQ: begin
               q_ff      <= q_fix;
               r_ff      <= r_fix;
               mean_ff   <= q_fix + XW'(({r_fix, 1'b0} >= {1'b0, n_ff}) ? 1 : 0);
               rd_ptr_ff <= '0;
               acc_ff    <= '0;
               sat_ff    <= 1'b0;
               state_ff  <= ST_PASS;
            end
            ST_PASS: begin
               if (rd_issue) begin
                  rd_ptr_ff <= rd_ptr_ff + CNT_W'(1);
               end
               if (v3_ff && !sat_ff) begin
                  if (acc_sum[ACC_W+2:ACC_W] != 3'b000) begin
                     sat_ff <= 1'b1;
                  end else begin
                     acc_ff <= acc_sum[ACC_W-1:0];
                  end
               end
               if (!rd_issue && !v1_ff && !v2_ff && !v3_ff) begin
                  if (sat_ff) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     mcand_ff  <= PW'(acc_ff);
                     mplier_ff <= n_ff;
                     p_ff      <= '0;
                     it_ff     <= '0;
                     state_ff  <= ST_MULA;
                  end
               end
            end
            ST_MULA, ST_MULB: begin
               if (mplier_ff[0]) begin
                  p_ff <= p_ff + mcand_ff;
               end
               mcand_ff  <= {mcand_ff[PW-2:0], 1'b0};
               mplier_ff <= mplier_ff >> 1;
               if (it_ff == IT_W'(CNT_W - 1)) begin
                  it_ff <= '0;
                  if (state_ff == ST_MULA) begin
                     state_ff <= ST_SUBR;
                  end else begin
                     rem_ff   <= '0;
                     dvs_ff   <= nsq;
                     state_ff <= ST_DIVN;
                  end
               end else begin
                  it_ff <= it_ff + IT_W'(1);
               end
            end
            ST_SUBR: begin
               // n*A - r^2 = n*ssd, never negative
               mcand_ff  <= p_ff - PW'(rsq);
               mplier_ff <= n_ff - CNT_W'(1);
               p_ff      <= '0;
               state_ff  <= ST_MULB;
            end
            ST_SQRT: begin
               if (it_ff == '0) begin
                  sv_ff  <= p_ff[RTW-1:0];
                  res_ff <= '0;
                  bit_ff <= RTW'(1) << (RTW - 2);
                  it_ff  <= IT_W'(1);
               end else begin
                  if (sv_ff >= rt_try) begin
                     sv_ff  <= sv_ff - rt_try;
                     res_ff <= (res_ff >> 1) + bit_ff;
                  end else begin
                     res_ff <= res_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
                  if (it_ff == IT_W'(rmje_pkg::ROOT_STEPS)) begin
                     it_ff    <= '0;
                     state_ff <= ST_FINISH;
                  end else begin
                     it_ff <= it_ff + IT_W'(1);
                  end
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_mean_ff  <= mean_ff;
                  if (sat_ff || (res_ff[RTW-1:rmje_pkg::ERROR_W] != '0)) begin
                     rsp_err_ff <= rmje_pkg::ERROR_MAX;
                  end else begin
                     rsp_err_ff <= res_ff[rmje_pkg::ERROR_W-1:0];
                  end
                  state_ff <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_mean  = rsp_mean_ff;
   assign rsp_row_error = rsp_err_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ROW_LEN))
      else $error("sample count beyond row length");
   a_rd_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PASS) |-> (rd_ptr_ff <= n_ff))
      else $error("pass read pointer beyond row");
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");
   a_sat_err: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && $past(sat_ff)) |-> (rsp_err_ff == rmje_pkg::ERROR_MAX))
      else $error("saturated row without maximum error");
`endif
endmodule
`default_nettype wire
